// File: hdl/sensor_packet_stream_parser_macros.svh
// Assertion macros used by the output buffer file.
`ifndef SENSOR_PACKET_STREAM_PARSER_MACROS_SVH
`define SENSOR_PACKET_STREAM_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SPSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SPSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SPSP_ASSERT_SAME(label, clk, rst, ante, cons, msg)

`define SPSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hdl/spsp_pkg.sv
package spsp_pkg;

  localparam logic [7:0] HDR0 = 8'h73;
  localparam logic [7:0] HDR1 = 8'h6E;
  localparam logic [7:0] HDR2 = 8'h70;
  localparam logic [15:0] HDR_SUM = 16'({8'h00, HDR0} + {8'h00, HDR1} + {8'h00, HDR2});

  localparam logic [3:0] COUNT_MASK = 4'hF;
  localparam logic       BIT_SET    = 1'b1;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_GOT_S = 3'd1;
  localparam logic [2:0] PH_GOT_N = 3'd2;
  localparam logic [2:0] PH_TYPE  = 3'd3;
  localparam logic [2:0] PH_ADDR  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_CKHI  = 3'd6;
  localparam logic [2:0] PH_CKLO  = 3'd7;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  address;
    logic [7:0]  packet_type;
    logic [7:0]  data_byte;
    logic [5:0]  data_index;
    logic [5:0]  payload_length;
    logic [15:0] packet_checksum;
    logic [15:0] local_checksum;
    logic        last;
  } result_t;

endpackage

// File: hdl/sensor_packet_stream_parser.sv
// channel | handshake            | payload
// input   | in_valid / in_stall  | rx_byte
// output  | out_valid / out_stall| kind, address, packet_type, data_byte, data_index,
//         |                      | payload_length, packet_checksum, local_checksum, last
// One byte is taken per cycle while in_stall is low; the header and checksum state updates in that cycle.
// A result beat is registered into the output buffer (output slot, or skid slot if the output is held).
// A two-beat output buffer lets input run while one result waits; in_stall rises
// only when both buffer slots hold beats.
// Synchronous reset returns the parser to the header hunt and empties the buffer.
module sensor_packet_stream_parser import spsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  address,
  output logic [7:0]  packet_type,
  output logic [7:0]  data_byte,
  output logic [5:0]  data_index,
  output logic [5:0]  payload_length,
  output logic [15:0] packet_checksum,
  output logic [15:0] local_checksum,
  output logic        last
);

  logic    accept;
  logic    push;
  logic    full;
  result_t result;
  result_t out_data;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  spsp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .push    (push),
    .result  (result)
  );

  spsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind            = out_data.kind;
  assign address         = out_data.address;
  assign packet_type     = out_data.packet_type;
  assign data_byte       = out_data.data_byte;
  assign data_index      = out_data.data_index;
  assign payload_length  = out_data.payload_length;
  assign packet_checksum = out_data.packet_checksum;
  assign local_checksum  = out_data.local_checksum;
  assign last            = out_data.last;

endmodule

// File: hdl/spsp_parse.sv
module spsp_parse import spsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       push,
  output result_t    result
);

  logic [2:0]  phase, phase_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  addr_reg, addr_reg_next;
  logic [5:0]  payload_count, payload_count_next;
  logic [5:0]  payload_len, payload_len_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  sum_high_byte, sum_high_byte_next;

  logic [6:0]  idx_plus;
  logic [15:0] rcv;
  logic [5:0]  len_of_byte;

  always_comb begin
    if (rx_byte[7] != BIT_SET) begin
      len_of_byte = 6'd0;
    end else if (rx_byte[6] != BIT_SET) begin
      len_of_byte = 6'd4;
    end else begin
      len_of_byte = {rx_byte[5:2] & COUNT_MASK, 2'b00};
    end
  end

  assign idx_plus = {1'b0, payload_count} + 7'd1;
  assign rcv      = {sum_high_byte, rx_byte};

  always_comb begin
    phase_next         = phase;
    type_reg_next      = type_reg;
    addr_reg_next      = addr_reg;
    payload_count_next = payload_count;
    payload_len_next   = payload_len;
    running_sum_next   = running_sum;
    sum_high_byte_next = sum_high_byte;
    push               = 1'b0;
    case (phase)
      PH_GOT_S: begin
        phase_next = (rx_byte == HDR1) ? PH_GOT_N : ((rx_byte == HDR0) ? PH_GOT_S : PH_HUNT);
      end
      PH_GOT_N: begin
        phase_next = (rx_byte == HDR2) ? PH_TYPE : ((rx_byte == HDR0) ? PH_GOT_S : PH_HUNT);
      end
      PH_TYPE: begin
        type_reg_next    = rx_byte;
        payload_len_next = len_of_byte;
        running_sum_next = HDR_SUM + {8'h00, rx_byte};
        phase_next       = PH_ADDR;
      end
      PH_ADDR: begin
        addr_reg_next      = rx_byte;
        running_sum_next   = running_sum + {8'h00, rx_byte};
        payload_count_next = 6'd0;
        phase_next         = (payload_len == 6'd0) ? PH_CKHI : PH_DATA;
      end
      PH_DATA: begin
        running_sum_next   = running_sum + {8'h00, rx_byte};
        payload_count_next = idx_plus[5:0];
        if (idx_plus >= {1'b0, payload_len}) begin
          phase_next = PH_CKHI;
        end
        push = accept;
      end
      PH_CKHI: begin
        sum_high_byte_next = rx_byte;
        phase_next         = PH_CKLO;
      end
      PH_CKLO: begin
        phase_next = PH_HUNT;
        push       = accept;
      end
      default: begin
        phase_next = (rx_byte == HDR0) ? PH_GOT_S : PH_HUNT;
      end
    endcase
  end

  always_comb begin
    result.address        = addr_reg_next;
    result.packet_type    = type_reg_next;
    result.payload_length = payload_len_next;
    result.local_checksum = running_sum_next;
    if (phase == PH_CKLO) begin
      result.kind            = (rcv == running_sum) ? KIND_GOOD : KIND_BAD;
      result.data_byte       = 8'h00;
      result.data_index      = 6'd0;
      result.packet_checksum = rcv;
      result.last            = 1'b1;
    end else begin
      result.kind            = KIND_DATA;
      result.data_byte       = rx_byte;
      result.data_index      = payload_count;
      result.packet_checksum = 16'h0000;
      result.last            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      type_reg      <= 8'h00;
      addr_reg      <= 8'h00;
      payload_count <= 6'd0;
      payload_len   <= 6'd0;
      running_sum   <= 16'h0000;
      sum_high_byte <= 8'h00;
    end else if (accept) begin
      phase         <= phase_next;
      type_reg      <= type_reg_next;
      addr_reg      <= addr_reg_next;
      payload_count <= payload_count_next;
      payload_len   <= payload_len_next;
      running_sum   <= running_sum_next;
      sum_high_byte <= sum_high_byte_next;
    end
  end

endmodule

// File: hdl/spsp_out_buf.sv
`include "sensor_packet_stream_parser_macros.svh"

module spsp_out_buf import spsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  `SPSP_ASSERT_SAME(a_skid_needs_out, clk, rst, skid_valid, out_valid, "skid beat without output beat")
  `SPSP_ASSERT_SAME(a_no_overflow, clk, rst, push, !skid_valid, "beat pushed into full buffer")
  `SPSP_ASSERT_NEXT(a_held_beat, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled beat changed")

endmodule
